FILE: sv/mscol_pkg.sv
// ----------------------------------------------------------------------------
// Magnetometer sample collector package
// Shared constants, codes and payload types of the sample collector.
// ----------------------------------------------------------------------------
package mscol_pkg;

	localparam int STORE_DEPTH = 256;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int FILL_W      = STORE_AW + 1;
	localparam int CNT_W       = 16;

	localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

	localparam logic [1:0] FUNC_PUSH  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_STOP  = 2'd2;

	localparam logic [2:0] ST_ACCEPTED = 3'd0;
	localparam logic [2:0] ST_IGNORED  = 3'd1;
	localparam logic [2:0] ST_SATURATED = 3'd2;
	localparam logic [2:0] ST_BAD_NORM = 3'd3;
	localparam logic [2:0] ST_CONTROL  = 3'd4;

	typedef struct packed {
		logic [1:0]          func;
		logic signed [15:0]  x;
		logic signed [15:0]  y;
		logic signed [15:0]  z;
		logic [23:0]         norm;
		logic                norm_bad;
		logic                sat_flag;
		logic [31:0]         now_ms;
	} sample_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [CNT_W-1:0]    accepted_count;
		logic [CNT_W-1:0]    rejected_count;
		logic [CNT_W-1:0]    saturated_count;
		logic [FILL_W-1:0]   stored_count;
		logic [STORE_AW-1:0] store_slot;
		logic [15:0]         span_x;
		logic [15:0]         span_y;
		logic [15:0]         span_z;
		logic [23:0]         norm_low;
		logic [23:0]         norm_high;
		logic [31:0]         last_accept_ms;
	} result_t;

	typedef struct packed {
		logic [15:0] span_x;
		logic [15:0] span_y;
		logic [15:0] span_z;
		logic [23:0] norm_low;
		logic [23:0] norm_high;
	} extremes_t;

endpackage

FILE: sv/mscol_extremes.sv
// ----------------------------------------------------------------------------
// Magnetometer sample collector extremes
// Tracks per-axis and norm minimum and maximum of accepted samples and
// presents the spans and norm bounds as they stand after the current update.
// ----------------------------------------------------------------------------
module mscol_extremes (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clear,
	input  logic                  update,
	input  mscol_pkg::sample_t    sample,
	output mscol_pkg::extremes_t  view
);
	import mscol_pkg::*;

	logic               seen_q;
	logic signed [15:0] amin_q [3];
	logic signed [15:0] amax_q [3];
	logic [23:0]        nmin_q;
	logic [23:0]        nmax_q;

	logic               seen_nxt;
	logic signed [15:0] amin_nxt [3];
	logic signed [15:0] amax_nxt [3];
	logic [23:0]        nmin_nxt;
	logic [23:0]        nmax_nxt;
	logic signed [15:0] v [3];
	logic [15:0]        span [3];

	assign v[0] = sample.x;
	assign v[1] = sample.y;
	assign v[2] = sample.z;

	always_comb begin
		seen_nxt = seen_q;
		nmin_nxt = nmin_q;
		nmax_nxt = nmax_q;
		for (int i = 0; i < 3; i++) begin
			amin_nxt[i] = amin_q[i];
			amax_nxt[i] = amax_q[i];
		end
		if (clear) begin
			seen_nxt = 1'b0;
			nmin_nxt = '0;
			nmax_nxt = '0;
			for (int i = 0; i < 3; i++) begin
				amin_nxt[i] = '0;
				amax_nxt[i] = '0;
			end
		end else if (update) begin
			seen_nxt = 1'b1;
			if (!seen_q) begin
				nmin_nxt = sample.norm;
				nmax_nxt = sample.norm;
				for (int i = 0; i < 3; i++) begin
					amin_nxt[i] = v[i];
					amax_nxt[i] = v[i];
				end
			end else begin
				if (sample.norm < nmin_q) nmin_nxt = sample.norm;
				if (sample.norm > nmax_q) nmax_nxt = sample.norm;
				for (int i = 0; i < 3; i++) begin
					if (v[i] < amin_q[i]) amin_nxt[i] = v[i];
					if (v[i] > amax_q[i]) amax_nxt[i] = v[i];
				end
			end
		end
		for (int i = 0; i < 3; i++) begin
			span[i] = 16'(amax_nxt[i] - amin_nxt[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			nmin_q <= '0;
			nmax_q <= '0;
			for (int i = 0; i < 3; i++) begin
				amin_q[i] <= '0;
				amax_q[i] <= '0;
			end
		end else if (clear || update) begin
			seen_q <= seen_nxt;
			nmin_q <= nmin_nxt;
			nmax_q <= nmax_nxt;
			for (int i = 0; i < 3; i++) begin
				amin_q[i] <= amin_nxt[i];
				amax_q[i] <= amax_nxt[i];
			end
		end
	end

	assign view.span_x    = span[0];
	assign view.span_y    = span[1];
	assign view.span_z    = span[2];
	assign view.norm_low  = nmin_nxt;
	assign view.norm_high = nmax_nxt;

endmodule

FILE: sv/mag_sample_collector_unit.sv
// ----------------------------------------------------------------------------
// Magnetometer sample collector
// Classifies magnetometer samples, keeps saturating counters and extremes,
// and writes accepted samples into a store, appending until full and then
// overwriting hashed entries.
// ----------------------------------------------------------------------------
// A result passes through the input register and then the result register.
// Throughput: one transaction per cycle; the input register and the result
// register each advance whenever the result register is free or being taken.
// Reset clears the armed flag, all counters, extremes and both valid flags.
// The store contents are undefined after reset and need no clearing pass.
module mag_sample_collector_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  mscol_pkg::sample_t   sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output mscol_pkg::result_t   result
);
	import mscol_pkg::*;

	sample_t             sample_s1;
	logic                valid_s1;
	result_t             result_q;
	logic                result_valid_q;

	logic                armed_q;
	logic [CNT_W-1:0]    good_q;
	logic [CNT_W-1:0]    reject_q;
	logic [CNT_W-1:0]    sat_q;
	logic [FILL_W-1:0]   fill_q;
	logic [STORE_AW-1:0] seq_q;
	logic [31:0]         last_q;

	logic [47:0]         store_mem [STORE_DEPTH];

	logic                advance;
	logic                commit;
	logic                clear;
	logic                accept;
	logic [2:0]          status;
	logic [STORE_AW-1:0] slot;
	logic [2*STORE_AW-1:0] hash_prod;
	logic                armed_nxt;
	logic [CNT_W-1:0]    good_nxt;
	logic [CNT_W-1:0]    reject_nxt;
	logic [CNT_W-1:0]    sat_nxt;
	logic [FILL_W-1:0]   fill_nxt;
	logic [STORE_AW-1:0] seq_nxt;
	logic [31:0]         last_nxt;
	extremes_t           ext_view;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == '1) ? c : c + CNT_W'(1);
	endfunction

	assign advance      = !result_valid_q || result_ready;
	assign sample_ready = !valid_s1 || advance;
	assign commit       = valid_s1 && advance;

	assign hash_prod = seq_q * HASH_MULT[STORE_AW-1:0];

	always_comb begin
		armed_nxt  = armed_q;
		good_nxt   = good_q;
		reject_nxt = reject_q;
		sat_nxt    = sat_q;
		fill_nxt   = fill_q;
		seq_nxt    = seq_q;
		last_nxt   = last_q;
		clear      = 1'b0;
		accept     = 1'b0;
		slot       = '0;
		status     = ST_IGNORED;
		case (sample_s1.func)
			FUNC_START: begin
				clear      = 1'b1;
				armed_nxt  = 1'b1;
				good_nxt   = '0;
				reject_nxt = '0;
				sat_nxt    = '0;
				fill_nxt   = '0;
				seq_nxt    = '0;
				last_nxt   = '0;
				status     = ST_CONTROL;
			end
			FUNC_STOP: begin
				armed_nxt = 1'b0;
				status    = ST_CONTROL;
			end
			FUNC_PUSH: begin
				if (!armed_q) begin
					status = ST_IGNORED;
				end else if (sample_s1.sat_flag) begin
					sat_nxt    = sat_inc(sat_q);
					reject_nxt = sat_inc(reject_q);
					status     = ST_SATURATED;
				end else if (sample_s1.norm_bad) begin
					reject_nxt = sat_inc(reject_q);
					status     = ST_BAD_NORM;
				end else begin
					accept = 1'b1;
					if (!fill_q[STORE_AW]) begin
						slot     = fill_q[STORE_AW-1:0];
						fill_nxt = fill_q + FILL_W'(1);
					end else begin
						slot = hash_prod[STORE_AW-1:0];
					end
					seq_nxt  = seq_q + STORE_AW'(1);
					good_nxt = sat_inc(good_q);
					last_nxt = sample_s1.now_ms;
					status   = ST_ACCEPTED;
				end
			end
			default: begin
				status = ST_IGNORED;
			end
		endcase
	end

	mscol_extremes u_extremes (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (commit && clear),
		.update (commit && accept),
		.sample (sample_s1),
		.view   (ext_view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			armed_q        <= 1'b0;
			good_q         <= '0;
			reject_q       <= '0;
			sat_q          <= '0;
			fill_q         <= '0;
			seq_q          <= '0;
			last_q         <= '0;
		end else begin
			if (sample_ready) begin
				valid_s1 <= sample_valid;
			end
			if (advance) begin
				result_valid_q <= valid_s1;
			end
			if (commit) begin
				armed_q  <= armed_nxt;
				good_q   <= good_nxt;
				reject_q <= reject_nxt;
				sat_q    <= sat_nxt;
				fill_q   <= fill_nxt;
				seq_q    <= seq_nxt;
				last_q   <= last_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
		if (commit) begin
			result_q.status          <= status;
			result_q.accepted_count  <= good_nxt;
			result_q.rejected_count  <= reject_nxt;
			result_q.saturated_count <= sat_nxt;
			result_q.stored_count    <= fill_nxt;
			result_q.store_slot      <= slot;
			result_q.span_x          <= ext_view.span_x;
			result_q.span_y          <= ext_view.span_y;
			result_q.span_z          <= ext_view.span_z;
			result_q.norm_low        <= ext_view.norm_low;
			result_q.norm_high       <= ext_view.norm_high;
			result_q.last_accept_ms  <= last_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && accept) begin
			store_mem[slot] <= {sample_s1.z, sample_s1.y, sample_s1.x};
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(STORE_DEPTH))
		else $error("Fill level exceeds the store depth.");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.status != ST_ACCEPTED |-> result_q.store_slot == '0)
		else $error("A transaction that was not accepted reports a store slot.");

	a_accept_stored: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.status == ST_ACCEPTED |-> result_q.stored_count != '0)
		else $error("An accepted sample left the store empty.");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit && accept && !fill_q[STORE_AW] |=> fill_q == $past(fill_q) + FILL_W'(1))
		else $error("Fill level did not advance on an appended sample.");
`endif

endmodule
